// ===== rtl/core/pwog_pkg.sv =====
// Shared types and constants for the pose window outlier gate.
// No dependencies; everything else in rtl/core imports this package.
`default_nettype none

package pwog_pkg;

   localparam int WINDOW_DEFAULT = 20;

   localparam int POS_W     = 24;
   localparam int SEC_W     = 32;
   localparam int USEC_W    = 20;
   localparam int HEAD_W    = 32;
   localparam int DEG_W     = 9;
   localparam int THR_W     = 16;
   localparam int STATUS_W  = 2;

   localparam logic [THR_W-1:0] THR_RESET = 16'd3000;

   // Heading reduction: bias by 1658 full turns so the value is never negative,
   // then split a full turn as 128 * 10125 and divide by reciprocal.
   localparam int HEAD_U_W   = 33;
   localparam logic [HEAD_U_W-1:0] HEAD_BIAS = 33'd2148768000;
   localparam int HEAD_LOW_W = 7;
   localparam int V_W        = HEAD_U_W - HEAD_LOW_W;
   localparam int TURN_CORE_W = 14;
   localparam logic [TURN_CORE_W-1:0] TURN_CORE = 14'd10125;
   localparam logic [V_W-1:0] RECIP_M = 26'd54296870;
   localparam int RECIP_K    = 39;
   localparam int Q1_W       = 12;
   localparam int TURN_R_W   = TURN_CORE_W + HEAD_LOW_W;

   // Degrees: 3600 = 16 * 225, again by reciprocal.
   localparam int DEG_LOW_W  = 4;
   localparam int DEG_RD_W   = TURN_R_W - DEG_LOW_W;
   localparam int DEG_M_W    = 18;
   localparam logic [DEG_M_W-1:0] DEG_M = 18'd149130;
   localparam int DEG_K      = 25;
   localparam int DEG_PROD_W = DEG_RD_W + DEG_M_W;
   localparam int REM2_W     = 13;
   localparam logic [TURN_R_W-1:0] ARCSEC_PER_DEG = 21'd3600;
   localparam logic [REM2_W-1:0] HALF_DEG       = 13'd1800;
   localparam logic [REM2_W-1:0] THREE_HALF_DEG = 13'd5400;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_IGNORED  = 2'd0,
      STATUS_ACCEPTED = 2'd1,
      STATUS_REJECTED = 2'd2
   } status_type;

   typedef struct packed {
      logic                     hypothesis_present;
      logic [SEC_W-1:0]         stamp_seconds;
      logic [USEC_W-1:0]        stamp_microseconds;
      logic signed [POS_W-1:0]  pose_x_mm;
      logic signed [POS_W-1:0]  pose_y_mm;
      logic signed [HEAD_W-1:0] heading_arcsec;
   } req_payload_type;

   typedef struct packed {
      status_type              status;
      logic signed [POS_W-1:0] held_x_mm;
      logic signed [POS_W-1:0] held_y_mm;
      logic [DEG_W-1:0]        held_heading_deg;
      logic                    window_full;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ===== rtl/core/pwog_if.sv =====
// Valid/ready channel interfaces for pose samples and gate results.
// Depends on pwog_pkg for the payload structs.
`default_nettype none

interface pwog_req_if
   import pwog_pkg::*;
;
   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface pwog_rsp_if
   import pwog_pkg::*;
;
   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pwog_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on pwog_pkg only for default sizes.
`default_nettype none

module pwog_ram
   import pwog_pkg::*;
#(
   parameter int WIDTH = 2 * POS_W,
   parameter int DEPTH = WINDOW_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/pose_window_outlier_gate.sv =====
// Pose outlier gate against a moving-average window of recent positions.
// Depends on pwog_pkg, pwog_if (channel interfaces) and pwog_ram (ring window).
//
// Usage:
//   req_beat carries one pose sample per beat (hypothesis flag, timestamp,
//   x/y in mm, heading in arc-seconds). rsp_beat returns exactly one result
//   beat per sample: status (ignored / accepted / rejected), the held pose
//   with heading in whole degrees, and the window-full flag.
//   csr_we/csr_wdata write the rejection radius in mm; write it while idle.
// Timing:
//   One sample per cycle sustained while rsp_beat does not stall. Each sample
//   passes the input register, then window/sum update with the gate
//   differences, squares, compare, result register. The running sums and
//   timestamp close their loop inside the first stage; the ring entry that
//   leaves the window is prefetched from the RAM when the previous sample commits.
// Reset:
//   Synchronous, active high. Clears sums, fill count, last timestamp,
//   held pose and the radius (3000 mm). Ring contents stay as they are;
//   no clearing pass is needed since entries are read only once written.
// Backpressure:
//   When rsp_beat stalls, the whole pipe holds and req_beat.ready drops in
//   the same cycle; no beat is dropped or repeated.
`default_nettype none

module pose_window_outlier_gate
   import pwog_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   pwog_req_if.sink          req_beat,
   pwog_rsp_if.source        rsp_beat,
   input  logic              csr_we,
   input  logic [THR_W-1:0]  csr_wdata
);

   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int ADDR_W = $clog2(WINDOW);
   localparam int SUM_W  = POS_W + CNT_W;
   localparam int DIFF_W = SUM_W + 1;
   localparam int SQ_W   = 2 * SUM_W;
   localparam int CMP_W  = SQ_W + 1;
   localparam int TW_W   = THR_W + CNT_W;
   localparam int T2_W   = 2 * TW_W;
   localparam int RAM_W  = 2 * POS_W;

   typedef struct packed {
      logic                    ignore;
      logic                    gate;
      logic                    window_full;
      logic [SUM_W-1:0]        dx;
      logic [SUM_W-1:0]        dy;
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic [Q1_W-1:0]         q1;
      logic [V_W-1:0]          v;
      logic [HEAD_LOW_W-1:0]   low;
   } s1_type;

   typedef struct packed {
      logic                    ignore;
      logic                    gate;
      logic                    window_full;
      logic [SQ_W-1:0]         sqx;
      logic [SQ_W-1:0]         sqy;
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic [TURN_R_W-1:0]     r;
   } s2_type;

   typedef struct packed {
      status_type              status;
      logic                    window_full;
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic [TURN_R_W-1:0]     r;
      logic [DEG_W-1:0]        q2;
   } s3_type;

   // control state
   logic                    s0_valid_ff, s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic [CNT_W-1:0]        fill_ff, fill_in;
   logic [ADDR_W-1:0]       slot_ff, slot_in;
   logic signed [SUM_W-1:0] sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic [SEC_W-1:0]        last_sec_ff;
   logic [USEC_W-1:0]       last_usec_ff;
   logic [THR_W-1:0]        thr_ff;
   logic signed [POS_W-1:0] held_x_ff, held_y_ff;
   logic [DEG_W-1:0]        held_deg_ff, deg_in;
   status_type              status_ff;
   logic                    full_ff;

   // payload
   req_payload_type s0_ff;
   s1_type          s1_ff, s1_in;
   s2_type          s2_ff, s2_in;
   s3_type          s3_ff, s3_in;
   logic [TW_W-1:0] tw_ff, tw_in;
   logic [T2_W-1:0] t2_ff, t2_in;

   logic adv, upd, commit, full_now;
   logic [RAM_W-1:0] ram_rd_data;

   assign adv = !rsp_valid_ff || rsp_beat.ready;
   assign req_beat.ready = adv;

   // ---------------- stage 1: window update and gate differences ----------------
   logic signed [POS_W-1:0]  old_x, old_y;
   logic signed [SUM_W-1:0]  x_ext, y_ext, drop_x, drop_y;
   logic signed [DIFF_W-1:0] win_s, wx, wy, dxs, dys;
   logic [HEAD_U_W-1:0]      head_u;
   logic [2*V_W-1:0]         q1_prod;

   assign upd = s0_valid_ff && s0_ff.hypothesis_present &&
                !(s0_ff.stamp_seconds == last_sec_ff &&
                  s0_ff.stamp_microseconds == last_usec_ff);
   assign commit   = adv && upd;
   assign full_now = (fill_ff == CNT_W'(WINDOW));

   assign old_x = ram_rd_data[RAM_W-1:POS_W];
   assign old_y = ram_rd_data[POS_W-1:0];

   assign x_ext  = SUM_W'(s0_ff.pose_x_mm);
   assign y_ext  = SUM_W'(s0_ff.pose_y_mm);
   assign drop_x = full_now ? SUM_W'(old_x) : '0;
   assign drop_y = full_now ? SUM_W'(old_y) : '0;

   assign sum_x_in = upd ? sum_x_ff - drop_x + x_ext : sum_x_ff;
   assign sum_y_in = upd ? sum_y_ff - drop_y + y_ext : sum_y_ff;
   assign fill_in  = (upd && !full_now) ? fill_ff + CNT_W'(1) : fill_ff;
   always_comb begin
      slot_in = slot_ff;
      if (upd) begin
         slot_in = (slot_ff == ADDR_W'(WINDOW - 1)) ? '0 : slot_ff + ADDR_W'(1);
      end
   end

   assign win_s = DIFF_W'(WINDOW);
   assign wx    = DIFF_W'(s0_ff.pose_x_mm) * win_s;
   assign wy    = DIFF_W'(s0_ff.pose_y_mm) * win_s;
   assign dxs   = wx - DIFF_W'(sum_x_ff);
   assign dys   = wy - DIFF_W'(sum_y_ff);

   // bias the heading by whole turns so it is never negative
   assign head_u  = {s0_ff.heading_arcsec[HEAD_W-1], s0_ff.heading_arcsec} + HEAD_BIAS;
   assign q1_prod = (2*V_W)'(head_u[HEAD_U_W-1:HEAD_LOW_W]) * (2*V_W)'(RECIP_M);

   always_comb begin
      s1_in.ignore      = !upd;
      s1_in.gate        = full_now;
      s1_in.window_full = (fill_in == CNT_W'(WINDOW));
      s1_in.dx          = dxs[DIFF_W-1] ? SUM_W'(-dxs) : SUM_W'(dxs);
      s1_in.dy          = dys[DIFF_W-1] ? SUM_W'(-dys) : SUM_W'(dys);
      s1_in.x           = s0_ff.pose_x_mm;
      s1_in.y           = s0_ff.pose_y_mm;
      s1_in.q1          = q1_prod[RECIP_K+Q1_W-1:RECIP_K];
      s1_in.v           = head_u[HEAD_U_W-1:HEAD_LOW_W];
      s1_in.low         = head_u[HEAD_LOW_W-1:0];
   end

   // keep reading the current slot while a sample waits in stage 0
   pwog_ram #(
      .WIDTH (RAM_W),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (commit),
      .wr_addr (slot_ff),
      .wr_data ({s0_ff.pose_x_mm, s0_ff.pose_y_mm}),
      .rd_addr (commit ? slot_in : slot_ff),
      .rd_data (ram_rd_data)
   );

   // ---------------- stage 2: squares, turn remainder ----------------
   logic [V_W-1:0]         q1_t, rem_w;
   logic [TURN_CORE_W:0]   rem_c;
   logic [TURN_CORE_W-1:0] rem_t;

   assign q1_t  = V_W'(s1_ff.q1) * V_W'(TURN_CORE);
   assign rem_w = s1_ff.v - q1_t;
   assign rem_c = rem_w[TURN_CORE_W:0];
   // quotient estimate runs at most one low
   assign rem_t = (rem_c >= (TURN_CORE_W+1)'(TURN_CORE)) ?
                  TURN_CORE_W'(rem_c - (TURN_CORE_W+1)'(TURN_CORE)) :
                  rem_c[TURN_CORE_W-1:0];

   always_comb begin
      s2_in.ignore      = s1_ff.ignore;
      s2_in.gate        = s1_ff.gate;
      s2_in.window_full = s1_ff.window_full;
      s2_in.sqx         = SQ_W'(s1_ff.dx) * SQ_W'(s1_ff.dx);
      s2_in.sqy         = SQ_W'(s1_ff.dy) * SQ_W'(s1_ff.dy);
      s2_in.x           = s1_ff.x;
      s2_in.y           = s1_ff.y;
      s2_in.r           = {rem_t, s1_ff.low};
   end

   // ---------------- stage 3: distance compare, degree estimate ----------------
   logic [CMP_W-1:0]      dist_sq;
   logic                  reject;
   logic [DEG_PROD_W-1:0] q2_prod;

   assign dist_sq = CMP_W'(s2_ff.sqx) + CMP_W'(s2_ff.sqy);
   assign reject  = s2_ff.gate && (dist_sq >= CMP_W'(t2_ff));
   assign q2_prod = DEG_PROD_W'(s2_ff.r[TURN_R_W-1:DEG_LOW_W]) * DEG_PROD_W'(DEG_M);

   always_comb begin
      if (s2_ff.ignore) begin
         s3_in.status = STATUS_IGNORED;
      end else if (reject) begin
         s3_in.status = STATUS_REJECTED;
      end else begin
         s3_in.status = STATUS_ACCEPTED;
      end
      s3_in.window_full = s2_ff.window_full;
      s3_in.x           = s2_ff.x;
      s3_in.y           = s2_ff.y;
      s3_in.r           = s2_ff.r;
      s3_in.q2          = q2_prod[DEG_K+DEG_W-1:DEG_K];
   end

   // ---------------- stage 4: round to whole degrees ----------------
   logic [TURN_R_W-1:0] q2_t, rem2_w;
   logic [REM2_W-1:0]   rem2;

   assign q2_t   = TURN_R_W'(s3_ff.q2) * ARCSEC_PER_DEG;
   assign rem2_w = s3_ff.r - q2_t;
   assign rem2   = rem2_w[REM2_W-1:0];

   // remainder spans up to two degrees since the estimate may run one low
   always_comb begin
      if (rem2 < HALF_DEG) begin
         deg_in = s3_ff.q2;
      end else if (rem2 == HALF_DEG) begin
         deg_in = s3_ff.q2 + DEG_W'(s3_ff.q2[0]);
      end else if (rem2 < THREE_HALF_DEG) begin
         deg_in = s3_ff.q2 + DEG_W'(1);
      end else if (rem2 == THREE_HALF_DEG) begin
         deg_in = s3_ff.q2 + DEG_W'(1) + DEG_W'(!s3_ff.q2[0]);
      end else begin
         deg_in = s3_ff.q2 + DEG_W'(2);
      end
   end

   // ---------------- threshold square ----------------
   assign tw_in = TW_W'(thr_ff) * TW_W'(WINDOW);
   assign t2_in = T2_W'(tw_ff) * T2_W'(tw_ff);

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fill_ff      <= '0;
         slot_ff      <= '0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         last_sec_ff  <= '0;
         last_usec_ff <= '0;
         thr_ff       <= THR_RESET;
         held_x_ff    <= '0;
         held_y_ff    <= '0;
         held_deg_ff  <= '0;
         status_ff    <= STATUS_IGNORED;
         full_ff      <= 1'b0;
      end else begin
         if (csr_we) begin
            thr_ff <= csr_wdata;
         end
         if (adv) begin
            s0_valid_ff  <= req_beat.valid;
            s1_valid_ff  <= s0_valid_ff;
            s2_valid_ff  <= s1_valid_ff;
            s3_valid_ff  <= s2_valid_ff;
            rsp_valid_ff <= s3_valid_ff;
            if (s3_valid_ff) begin
               status_ff <= s3_ff.status;
               full_ff   <= s3_ff.window_full;
               if (s3_ff.status == STATUS_ACCEPTED) begin
                  held_x_ff   <= s3_ff.x;
                  held_y_ff   <= s3_ff.y;
                  held_deg_ff <= deg_in;
               end
            end
         end
         if (commit) begin
            fill_ff      <= fill_in;
            slot_ff      <= slot_in;
            sum_x_ff     <= sum_x_in;
            sum_y_ff     <= sum_y_in;
            last_sec_ff  <= s0_ff.stamp_seconds;
            last_usec_ff <= s0_ff.stamp_microseconds;
         end
      end
   end

   always_ff @(posedge clock) begin
      tw_ff <= tw_in;
      t2_ff <= t2_in;
      if (adv) begin
         s0_ff <= req_beat.data;
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
      end
   end

   assign rsp_beat.valid                 = rsp_valid_ff;
   assign rsp_beat.data.status           = status_ff;
   assign rsp_beat.data.held_x_mm        = held_x_ff;
   assign rsp_beat.data.held_y_mm        = held_y_ff;
   assign rsp_beat.data.held_heading_deg = held_deg_ff;
   assign rsp_beat.data.window_full      = full_ff;

endmodule

`default_nettype wire

// ===== rtl/core/pwog_checker.sv =====
// Port-level assertions for pose_window_outlier_gate, attached by bind.
// Depends on pwog_pkg for the result payload type and status codes.
`default_nettype none

module pwog_checker
   import pwog_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  rsp_payload_type rsp_data
);

   logic req_fire, rsp_fire;
   logic seen_full_ff;
   logic signed [POS_W-1:0] last_x_ff, last_y_ff;
   logic [DEG_W-1:0] last_deg_ff;
   logic [3:0] pending_ff;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_full_ff <= 1'b0;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         last_deg_ff  <= '0;
         pending_ff   <= '0;
      end else begin
         pending_ff <= pending_ff + 4'(req_fire) - 4'(rsp_fire);
         if (rsp_fire) begin
            seen_full_ff <= seen_full_ff || rsp_data.window_full;
            last_x_ff    <= rsp_data.held_x_mm;
            last_y_ff    <= rsp_data.held_y_mm;
            last_deg_ff  <= rsp_data.held_heading_deg;
         end
      end
   end

   // a result always answers an earlier sample
   a_no_orphan_result: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> pending_ff != 4'd0)
      else $error("result beat without an outstanding sample");

   // the window never empties again once full
   a_full_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && seen_full_ff |-> rsp_data.window_full)
      else $error("window_full dropped after the window filled");

   // only an accepted sample moves the held pose
   a_held_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_data.status != STATUS_ACCEPTED |->
         rsp_data.held_x_mm == last_x_ff && rsp_data.held_y_mm == last_y_ff &&
         rsp_data.held_heading_deg == last_deg_ff)
      else $error("held pose changed on a sample that was not accepted");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

endmodule

bind pose_window_outlier_gate pwog_checker u_pwog_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_beat.valid),
   .req_ready (req_beat.ready),
   .rsp_valid (rsp_beat.valid),
   .rsp_ready (rsp_beat.ready),
   .rsp_data  (rsp_beat.data)
);

`default_nettype wire

// ===== dv/pwog_tb_pkg.sv =====
// Scoreboard for the pose window outlier gate testbench: predicts each result beat.
// Depends on pwog_pkg for the payload structs, widths and status codes.
package pwog_tb_pkg;
   import pwog_pkg::*;

   localparam int     GATE_WINDOW   = WINDOW_DEFAULT;
   localparam longint TURN_ARCSEC   = 1296000;
   localparam longint DEGREE_ARCSEC = 3600;

   class pose_gate_scoreboard;
      logic signed [POS_W-1:0] ring_x [GATE_WINDOW];
      logic signed [POS_W-1:0] ring_y [GATE_WINDOW];
      int                      fill_count;
      int                      write_slot;
      longint                  sum_x;
      longint                  sum_y;
      logic [SEC_W-1:0]        last_sec;
      logic [USEC_W-1:0]       last_usec;
      rsp_payload_type         held_pose;
      logic [THR_W-1:0]        reject_mm;
      rsp_payload_type         gate_results [$];
      int                      error_count;

      function new();
         fill_count  = 0;
         write_slot  = 0;
         sum_x       = 0;
         sum_y       = 0;
         last_sec    = '0;
         last_usec   = '0;
         held_pose   = '0;
         reject_mm   = THR_RESET;
         error_count = 0;
      endfunction

      function void set_reject_distance(logic [THR_W-1:0] mm);
         reject_mm = mm;
      endfunction

      function bit is_new_stamp(logic [SEC_W-1:0] sec, logic [USEC_W-1:0] usec);
         return !(sec == last_sec && usec == last_usec);
      endfunction

      function int pending();
         return gate_results.size();
      endfunction

      // Reduce modulo one turn, then round half to even to whole degrees.
      function logic [DEG_W-1:0] heading_degrees(logic signed [HEAD_W-1:0] arcsec);
         longint r;
         longint q;
         longint rem;
         r = longint'(arcsec) % TURN_ARCSEC;
         if (r < 0) begin
            r += TURN_ARCSEC;
         end
         q   = r / DEGREE_ARCSEC;
         rem = r % DEGREE_ARCSEC;
         if (rem > DEGREE_ARCSEC / 2 || (rem == DEGREE_ARCSEC / 2 && q[0])) begin
            q++;
         end
         return DEG_W'(q);
      endfunction

      function void note_sample(req_payload_type s);
         rsp_payload_type r;
         status_type      st;
         longint          dx;
         longint          dy;
         longint          lim;
         bit              full;
         bit              reject;
         st = STATUS_IGNORED;
         if (s.hypothesis_present && is_new_stamp(s.stamp_seconds, s.stamp_microseconds)) begin
            full      = fill_count >= GATE_WINDOW;
            reject    = 1'b0;
            last_sec  = s.stamp_seconds;
            last_usec = s.stamp_microseconds;
            if (full) begin
               dx     = GATE_WINDOW * longint'(s.pose_x_mm) - sum_x;
               dy     = GATE_WINDOW * longint'(s.pose_y_mm) - sum_y;
               lim    = GATE_WINDOW * longint'(reject_mm);
               reject = dx * dx + dy * dy >= lim * lim;
            end
            if (reject) begin
               st = STATUS_REJECTED;
            end else begin
               st                         = STATUS_ACCEPTED;
               held_pose.held_x_mm        = s.pose_x_mm;
               held_pose.held_y_mm        = s.pose_y_mm;
               held_pose.held_heading_deg = heading_degrees(s.heading_arcsec);
            end
            // a rejected sample still enters the window
            if (full) begin
               sum_x -= ring_x[write_slot];
               sum_y -= ring_y[write_slot];
            end else begin
               fill_count++;
            end
            ring_x[write_slot] = s.pose_x_mm;
            ring_y[write_slot] = s.pose_y_mm;
            sum_x += s.pose_x_mm;
            sum_y += s.pose_y_mm;
            write_slot = (write_slot + 1) % GATE_WINDOW;
         end
         r             = held_pose;
         r.status      = st;
         r.window_full = fill_count >= GATE_WINDOW;
         gate_results.push_back(r);
      endfunction

      function void compare_field(string field, logic signed [63:0] want,
                                  logic signed [63:0] got, longint at);
         if (got !== want) begin
            $display("%0d ns: %s expected %0d actual %0d", at, field, want, got);
            error_count++;
         end
      endfunction

      function void check_result(rsp_payload_type got, longint at);
         rsp_payload_type want;
         if (gate_results.size() == 0) begin
            $display("%0d ns: result beat with no pending sample, expected none actual %0h",
                     at, got);
            error_count++;
            return;
         end
         want = gate_results.pop_front();
         compare_field("status", want.status, got.status, at);
         compare_field("held_x_mm", want.held_x_mm, got.held_x_mm, at);
         compare_field("held_y_mm", want.held_y_mm, got.held_y_mm, at);
         compare_field("held_heading_deg", want.held_heading_deg, got.held_heading_deg, at);
         compare_field("window_full", want.window_full, got.window_full, at);
      endfunction
   endclass

endpackage

// ===== dv/tb_pose_window_outlier_gate.sv =====
// Top-level testbench for pose_window_outlier_gate: directed and random pose beats,
// random stalls on both channels, radius writes between phases.
// Depends on pwog_pkg, pwog_if, pwog_tb_pkg and the gate RTL.
module tb_pose_window_outlier_gate;
   timeunit 1ns;
   timeprecision 1ps;

   import pwog_pkg::*;
   import pwog_tb_pkg::*;

   localparam int IDLE_LIMIT  = 2000;
   localparam int PHASE_ITEMS = 138;
   localparam int PHASES      = 8;
   localparam int LONG_HOLD   = 60;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_we;
   logic [THR_W-1:0] csr_wdata;

   pwog_req_if req_if ();
   pwog_rsp_if rsp_if ();

   pose_window_outlier_gate i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_beat  (req_if),
      .rsp_beat  (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   pose_gate_scoreboard gate_model = new();

   int                center_x;
   int                center_y;
   logic [SEC_W-1:0]  stamp_sec;
   logic [USEC_W-1:0] stamp_usec;
   bit                sender_burst;
   bit                receiver_burst;
   int                results_seen;
   logic [THR_W-1:0]  phase_radius [PHASES];

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         gate_model.note_sample(req_if.data);
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         gate_model.check_result(rsp_if.data, $time);
      end
   end

   // Abort when no beat moves on either channel for too long.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("tb: failure");
      $finish;
   end

   // Result side: random stalls, plus two long holds so the pipe fills up.
   initial begin
      int gap;
      rsp_if.ready <= 1'b0;
      receiver_burst = 1'b0;
      results_seen   = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = receiver_burst ? 0 : $urandom_range(0, 3);
         if (results_seen == 300 || results_seen == 900) begin
            gap = LONG_HOLD;
         end
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (rsp_if.valid !== 1'b1) @(posedge clock);
         results_seen++;
         @(negedge clock);
         if ($urandom_range(0, 39) == 0) begin
            receiver_burst = !receiver_burst;
         end
      end
   end

   task automatic send_sample(input req_payload_type s);
      int gap;
      gap = sender_burst ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= s;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      @(negedge clock);
      if ($urandom_range(0, 39) == 0) begin
         sender_burst = !sender_burst;
      end
   endtask

   task automatic send_point(input bit hyp, input logic [SEC_W-1:0] sec,
                             input logic [USEC_W-1:0] usec, input int x, input int y,
                             input int heading);
      req_payload_type s;
      s.hypothesis_present = hyp;
      s.stamp_seconds      = sec;
      s.stamp_microseconds = usec;
      s.pose_x_mm          = POS_W'(x);
      s.pose_y_mm          = POS_W'(y);
      s.heading_arcsec     = heading;
      send_sample(s);
   endtask

   // Mostly well-formed samples scattered around a moving center; some noise,
   // repeated stamps and samples without a hypothesis.
   function automatic req_payload_type pick_pose_sample(input int spread);
      req_payload_type s;
      int              mode;
      int              lim;
      int              usec;
      mode = $urandom_range(0, 99);
      if ($urandom_range(0, 19) == 0) begin
         stamp_sec  = $urandom;
         stamp_usec = USEC_W'($urandom_range(0, 20'hFFFFF));
      end else begin
         usec = int'(stamp_usec) + $urandom_range(1, 40000);
         if (usec > 999999) begin
            usec -= 1000000;
            stamp_sec++;
         end
         stamp_usec = USEC_W'(usec);
      end
      if (mode < 3) begin
         lim      = 8388600 - 2 * spread;
         center_x = int'($urandom_range(0, 2 * lim)) - lim;
         center_y = int'($urandom_range(0, 2 * lim)) - lim;
      end
      s.hypothesis_present = 1'b1;
      s.stamp_seconds      = stamp_sec;
      s.stamp_microseconds = stamp_usec;
      s.pose_x_mm          = POS_W'(center_x + int'($urandom_range(0, 2 * spread)) - spread);
      s.pose_y_mm          = POS_W'(center_y + int'($urandom_range(0, 2 * spread)) - spread);
      if ($urandom_range(0, 2) == 0) begin
         // land near half-degree boundaries
         s.heading_arcsec = (int'($urandom_range(0, 1440)) - 720) * 1800
                            + int'($urandom_range(0, 2)) - 1;
      end else begin
         s.heading_arcsec = $urandom;
      end
      if (mode == 3) begin
         s.pose_x_mm = POS_W'($urandom);
         s.pose_y_mm = POS_W'($urandom);
      end else if (mode < 13) begin
         s.hypothesis_present = 1'($urandom_range(0, 1));
         s.stamp_seconds      = $urandom;
         s.stamp_microseconds = USEC_W'($urandom_range(0, 20'hFFFFF));
         s.pose_x_mm          = POS_W'($urandom);
         s.pose_y_mm          = POS_W'($urandom);
         if (s.hypothesis_present) begin
            s.hypothesis_present = 1'b0;
         end
      end else if (mode < 21) begin
         s.stamp_seconds      = gate_model.last_sec;
         s.stamp_microseconds = gate_model.last_usec;
      end
      return s;
   endfunction

   task automatic run_gate_phase(input int quota, input int spread);
      req_payload_type s;
      int              counted;
      counted = 0;
      while (counted < quota) begin
         s = pick_pose_sample(spread);
         if (s.hypothesis_present &&
             gate_model.is_new_stamp(s.stamp_seconds, s.stamp_microseconds)) begin
            counted++;
         end
         send_sample(s);
      end
   endtask

   // Write only once every result is back and the pipe has drained.
   task automatic write_reject_distance(input logic [THR_W-1:0] mm);
      req_if.valid <= 1'b0;
      while (gate_model.pending() != 0) @(posedge clock);
      repeat (8) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= mm;
      @(negedge clock);
      csr_we <= 1'b0;
      gate_model.set_reject_distance(mm);
   endtask

   initial begin
      int dir_heading [20];
      reset        <= 1'b1;
      csr_we       <= 1'b0;
      csr_wdata    <= '0;
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      sender_burst = 1'b0;
      dir_heading  = '{0, 1800, 5400, 1295999, -1, 1294200, 2147483647, 32'sh8000_0000,
                       648000, -648000, 3599, 1799, 1801, 1296000, -1296000, 1297800,
                       -1800, -5400, 900, 3600};
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // stamp equal to the reset stamp, then no hypothesis: both ignored
      send_point(1'b1, 0, 0, 8388607, -8388608, 0);
      send_point(1'b0, 7, 5, -8388608, 8388607, 1800);
      // fill the window at one point while walking the heading rounding cases
      for (int i = 0; i < 20; i++) begin
         send_point(1'b1, 100, (i == 19) ? 20'hFFFFF : USEC_W'(i + 1), 1000, -2000,
                    dir_heading[i]);
         if (i == 0) begin
            send_point(1'b1, 100, 1, 5000, 5000, 3600);
         end
      end
      // exactly at the radius from the mean: reject
      send_point(1'b1, 101, 0, 4000, -2000, 0);
      send_point(1'b1, 102, 0, 8388607, -8388608, 1);
      send_point(1'b1, 103, 0, -8388608, 8388607, 2);

      stamp_sec  = 200;
      stamp_usec = '0;
      center_x   = 0;
      center_y   = 0;
      phase_radius[0] = '0;
      phase_radius[1] = 16'hFFFF;
      phase_radius[2] = 16'd1;
      phase_radius[3] = THR_RESET;
      phase_radius[4] = THR_W'($urandom_range(0, 65535));
      phase_radius[5] = THR_W'($urandom_range(10, 400));
      phase_radius[6] = THR_W'($urandom_range(400, 20000));
      phase_radius[7] = THR_W'($urandom_range(0, 65535));
      for (int p = 0; p < PHASES; p++) begin
         write_reject_distance(phase_radius[p]);
         run_gate_phase(PHASE_ITEMS, int'(phase_radius[p]) * 3 / 2 + 20);
      end

      req_if.valid <= 1'b0;
      while (gate_model.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (gate_model.error_count == 0 && gate_model.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
